// File: rtl/assert_macros.svh
// Assertion macros shared by the ichimoku midpoint RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ICHI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check a property on every clock edge, reset included.
`define ICHI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) \
      else $error(msg);

`endif

// File: rtl/ichi_pkg.sv
// Shared constants and types for the ichimoku window midpoint block.
`timescale 1ns / 1ps

package ichi_pkg;

   localparam int LEN_BITS       = 7;
   localparam int CSR_IDX_BITS   = 2;
   localparam int WINDOW_MAX_DEF = 64;
   localparam int PRICE_BITS_DEF = 32;

   localparam logic [LEN_BITS-1:0] CONV_LEN_RESET  = 7'd9;
   localparam logic [LEN_BITS-1:0] BASE_LEN_RESET  = 7'd26;
   localparam logic [LEN_BITS-1:0] SPANB_LEN_RESET = 7'd52;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CONV_LEN  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_LEN  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPANB_LEN = 2'd2;

   // Control of the shared max/min unit.
   typedef struct packed {
      logic step;   // a history entry is on the data inputs
      logic first;  // entry is the newest bar: restart the extremes
   } ext_ctrl_type;

endpackage

// File: rtl/ichimoku_window_midpoints.sv
// Ichimoku window midpoints: top level with bar history, scan sequencer and result register.
//
// One bar is accepted at a time; the block then walks the stored bars from newest to oldest
// through a single max/min compare unit, reading one history entry per cycle, and snapshots
// the running (highest high + lowest low) as each of the conversion, base and span B windows
// closes. The scan makes N history reads, where N is the longest of the three effective window
// lengths (at most WINDOW_MAX, 64 by default, and never more than the bars held so far). The
// result is offered after the scan drains and span A is summed; the next bar is accepted
// only after the result has been taken. No clearing pass is needed after reset.
// The user must write lengths through the csr_ port only while the block is idle; the block
// does not enforce this. A length of 0 acts as 1 and a length above WINDOW_MAX acts as WINDOW_MAX.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ichimoku_window_midpoints #(
   parameter int WINDOW_MAX = ichi_pkg::WINDOW_MAX_DEF,
   parameter int PRICE_BITS = ichi_pkg::PRICE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [PRICE_BITS-1:0]             req_bar_high,
   input  logic [PRICE_BITS-1:0]             req_bar_low,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [PRICE_BITS:0]               rsp_conversion_line,
   output logic [PRICE_BITS:0]               rsp_base_line,
   output logic [PRICE_BITS+1:0]             rsp_lead_span_a,
   output logic [PRICE_BITS:0]               rsp_lead_span_b,
   output logic                              rsp_conversion_ready,
   output logic                              rsp_base_ready,
   output logic                              rsp_span_b_ready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ichi_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [ichi_pkg::LEN_BITS-1:0]     csr_data
);
   import ichi_pkg::*;

   localparam int AGE_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W = (LEN_BITS > CNT_W) ? LEN_BITS : CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_SUM,
      ST_RESULT
   } state_type;

   // Control state
   state_type            state_ff,     state_in;
   logic [AGE_W-1:0]     write_slot_ff, write_slot_in;
   logic [CNT_W-1:0]     bars_held_ff, bars_held_in;
   logic [AGE_W-1:0]     rd_ptr_ff,    rd_ptr_in;
   logic [AGE_W-1:0]     age0_ff,      age0_in;
   logic                 st1_valid_ff, st1_valid_in;
   logic                 st2_valid_ff, st2_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEN_BITS-1:0]  conv_len_ff,  conv_len_in;
   logic [LEN_BITS-1:0]  base_len_ff,  base_len_in;
   logic [LEN_BITS-1:0]  spanb_len_ff, spanb_len_in;

   // Payload
   logic [AGE_W-1:0]     age1_ff;
   logic [AGE_W-1:0]     age2_ff;
   logic [AGE_W-1:0]     last_conv_ff, last_base_ff, last_spanb_ff, last_max_ff;
   logic                 ready_conv_ff, ready_base_ff, ready_spanb_ff;
   logic [PRICE_BITS:0]  conv_ff, base_ff, spanb_ff;
   logic [PRICE_BITS+1:0] span_a_ff;

   logic                 accept;
   logic [CNT_W-1:0]     len_conv, len_base, len_spanb;
   logic [CNT_W-1:0]     n_conv, n_base, n_spanb;
   logic [AGE_W-1:0]     last_conv_in, last_base_in, last_spanb_in, last_max_in;
   logic [2*PRICE_BITS-1:0] rd_data;
   logic [PRICE_BITS:0]  extreme_sum;
   ext_ctrl_type         ext_ctrl;
   logic                 mem_rd_en;

   function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_BITS-1:0] len);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(len);
      if (wide == '0) begin
         return CNT_W'(1);
      end else if (wide > CMP_W'(WINDOW_MAX)) begin
         return CNT_W'(WINDOW_MAX);
      end else begin
         return CNT_W'(wide);
      end
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign mem_rd_en = (state_ff == ST_SCAN);

   // Window sizes for the bar being accepted, counted with that bar included.
   always_comb begin
      len_conv  = clamp_len(conv_len_ff);
      len_base  = clamp_len(base_len_ff);
      len_spanb = clamp_len(spanb_len_ff);
      n_conv    = (len_conv  < bars_held_in) ? len_conv  : bars_held_in;
      n_base    = (len_base  < bars_held_in) ? len_base  : bars_held_in;
      n_spanb   = (len_spanb < bars_held_in) ? len_spanb : bars_held_in;
      last_conv_in  = AGE_W'(n_conv  - CNT_W'(1));
      last_base_in  = AGE_W'(n_base  - CNT_W'(1));
      last_spanb_in = AGE_W'(n_spanb - CNT_W'(1));
      last_max_in   = (last_conv_in > last_base_in) ? last_conv_in : last_base_in;
      if (last_spanb_in > last_max_in) begin
         last_max_in = last_spanb_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      bars_held_in  = (bars_held_ff == CNT_W'(WINDOW_MAX)) ? bars_held_ff
                                                          : bars_held_ff + CNT_W'(1);
      rd_ptr_in     = rd_ptr_ff;
      age0_in       = age0_ff;
      st1_valid_in  = 1'b0;
      st2_valid_in  = st1_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      conv_len_in   = conv_len_ff;
      base_len_in   = base_len_ff;
      spanb_len_in  = spanb_len_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CONV_LEN:  conv_len_in  = csr_data;
            CSR_BASE_LEN:  base_len_in  = csr_data;
            CSR_SPANB_LEN: spanb_len_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               write_slot_in = (write_slot_ff == AGE_W'(WINDOW_MAX - 1)) ? '0
                                                                        : write_slot_ff + 1'b1;
               rd_ptr_in     = write_slot_ff;
               age0_in       = '0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one history read per cycle, newest bar first.
            st1_valid_in = 1'b1;
            rd_ptr_in    = (rd_ptr_ff == '0) ? AGE_W'(WINDOW_MAX - 1) : rd_ptr_ff - 1'b1;
            age0_in      = age0_ff + 1'b1;
            if (age0_ff == last_max_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (st2_valid_ff && (age2_ff == last_max_ff)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (!accept) begin
         bars_held_in = bars_held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         write_slot_ff <= '0;
         bars_held_ff  <= '0;
         rd_ptr_ff     <= '0;
         age0_ff       <= '0;
         st1_valid_ff  <= 1'b0;
         st2_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         conv_len_ff   <= CONV_LEN_RESET;
         base_len_ff   <= BASE_LEN_RESET;
         spanb_len_ff  <= SPANB_LEN_RESET;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         bars_held_ff  <= bars_held_in;
         rd_ptr_ff     <= rd_ptr_in;
         age0_ff       <= age0_in;
         st1_valid_ff  <= st1_valid_in;
         st2_valid_ff  <= st2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         conv_len_ff   <= conv_len_in;
         base_len_ff   <= base_len_in;
         spanb_len_ff  <= spanb_len_in;
      end
   end

   // Window bookkeeping for the transaction in flight, and the result snapshots.
   always_ff @(posedge clock) begin
      age1_ff <= age0_ff;
      age2_ff <= age1_ff;
      if (accept) begin
         last_conv_ff   <= last_conv_in;
         last_base_ff   <= last_base_in;
         last_spanb_ff  <= last_spanb_in;
         last_max_ff    <= last_max_in;
         ready_conv_ff  <= (bars_held_in >= len_conv);
         ready_base_ff  <= (bars_held_in >= len_base);
         ready_spanb_ff <= (bars_held_in >= len_spanb);
      end
      if (st2_valid_ff && (age2_ff == last_conv_ff)) begin
         conv_ff <= extreme_sum;
      end
      if (st2_valid_ff && (age2_ff == last_base_ff)) begin
         base_ff <= extreme_sum;
      end
      if (st2_valid_ff && (age2_ff == last_spanb_ff)) begin
         spanb_ff <= extreme_sum;
      end
      if (state_ff == ST_SUM) begin
         span_a_ff <= {1'b0, conv_ff} + {1'b0, base_ff};
      end
   end

   assign ext_ctrl.step  = st1_valid_ff;
   assign ext_ctrl.first = (age1_ff == '0);

   ichi_hist #(
      .DEPTH  (WINDOW_MAX),
      .DATA_W (2 * PRICE_BITS)
   ) u_hist (
      .clock      (clock),
      .wr_en      (accept),
      .wr_addr    (write_slot_ff),
      .wr_data    ({req_bar_high, req_bar_low}),
      .rd_en      (mem_rd_en),
      .rd_addr    (rd_ptr_ff),
      .rd_data_ff (rd_data)
   );

   ichi_extreme #(
      .PRICE_BITS (PRICE_BITS)
   ) u_extreme (
      .clock       (clock),
      .ctrl        (ext_ctrl),
      .high        (rd_data[2*PRICE_BITS-1:PRICE_BITS]),
      .low         (rd_data[PRICE_BITS-1:0]),
      .extreme_sum (extreme_sum)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_conversion_line  = conv_ff;
   assign rsp_base_line        = base_ff;
   assign rsp_lead_span_a      = span_a_ff;
   assign rsp_lead_span_b      = spanb_ff;
   assign rsp_conversion_ready = ready_conv_ff;
   assign rsp_base_ready       = ready_base_ff;
   assign rsp_span_b_ready     = ready_spanb_ff;

   `ICHI_ASSERT(a_no_accept_with_result, clock, reset, rsp_valid_ff |-> !req_ready, "new bar taken while a result is pending")
   `ICHI_ASSERT(a_bars_counted, clock, reset, accept |=> (bars_held_ff != '0), "bar accepted but history count is zero")
   `ICHI_ASSERT(a_scan_in_window, clock, reset, st2_valid_ff |-> (age2_ff <= last_max_ff), "scan ran past the longest window")
   `ICHI_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid_ff, "result valid right after reset")

endmodule

// File: rtl/ichi_hist.sv
// History ring memory of (high, low) pairs with a registered read port.
`timescale 1ns / 1ps

module ichi_hist #(
   parameter int DEPTH  = ichi_pkg::WINDOW_MAX_DEF,
   parameter int DATA_W = 2 * ichi_pkg::PRICE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data_ff
);
   import ichi_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// File: rtl/ichi_extreme.sv
// Shared compare unit: running highest high and lowest low, plus their sum.
`timescale 1ns / 1ps

module ichi_extreme #(
   parameter int PRICE_BITS = ichi_pkg::PRICE_BITS_DEF
) (
   input  logic                    clock,
   input  ichi_pkg::ext_ctrl_type  ctrl,
   input  logic [PRICE_BITS-1:0]   high,
   input  logic [PRICE_BITS-1:0]   low,
   output logic [PRICE_BITS:0]     extreme_sum
);
   import ichi_pkg::*;

   logic [PRICE_BITS-1:0] max_ff;
   logic [PRICE_BITS-1:0] min_ff;
   logic [PRICE_BITS-1:0] max_in;
   logic [PRICE_BITS-1:0] min_in;

   always_comb begin
      max_in = max_ff;
      min_in = min_ff;
      if (ctrl.step) begin
         if (ctrl.first || (high > max_ff)) begin
            max_in = high;
         end
         if (ctrl.first || (low < min_ff)) begin
            min_in = low;
         end
      end
   end

   always_ff @(posedge clock) begin
      max_ff <= max_in;
      min_ff <= min_in;
   end

   assign extreme_sum = {1'b0, max_ff} + {1'b0, min_ff};

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ichimoku window midpoint block.
module tb;
   import ichi_pkg::*;

   localparam int PRICE_BITS   = PRICE_BITS_DEF;
   localparam int WINDOW_MAX   = WINDOW_MAX_DEF;
   localparam int CHK_W        = PRICE_BITS + 2;
   localparam int RANDOM_BARS  = 1350;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE       = 8;
   localparam int TAIL_CYCLES  = WINDOW_MAX + 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef logic [PRICE_BITS-1:0] price_type;

   typedef struct {
      logic [PRICE_BITS:0]   conv;
      logic [PRICE_BITS:0]   base;
      logic [PRICE_BITS+1:0] span_a;
      logic [PRICE_BITS:0]   span_b;
      logic                  conv_full;
      logic                  base_full;
      logic                  span_b_full;
   } midpoint_set_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   price_type                 req_bar_high;
   price_type                 req_bar_low;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [PRICE_BITS:0]       rsp_conversion_line;
   logic [PRICE_BITS:0]       rsp_base_line;
   logic [PRICE_BITS+1:0]     rsp_lead_span_a;
   logic [PRICE_BITS:0]       rsp_lead_span_b;
   logic                      rsp_conversion_ready;
   logic                      rsp_base_ready;
   logic                      rsp_span_b_ready;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [LEN_BITS-1:0]       csr_data;

   // Shadow of the block's history and length registers
   price_type           hist_high [WINDOW_MAX];
   price_type           hist_low [WINDOW_MAX];
   int unsigned         next_slot = 0;
   int unsigned         bars_held = 0;
   logic [LEN_BITS-1:0] conv_len  = CONV_LEN_RESET;
   logic [LEN_BITS-1:0] base_len  = BASE_LEN_RESET;
   logic [LEN_BITS-1:0] spanb_len = SPANB_LEN_RESET;

   midpoint_set_type pending_midpoints[$];
   bit            failed      = 1'b0;
   int unsigned   burst_left  = 0;
   int unsigned   cycle_count = 0;
   int unsigned   rx_left     = 0;
   int unsigned   rx_mode     = 0;

   ichimoku_window_midpoints i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_bar_high         (req_bar_high),
      .req_bar_low          (req_bar_low),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_conversion_line  (rsp_conversion_line),
      .rsp_base_line        (rsp_base_line),
      .rsp_lead_span_a      (rsp_lead_span_a),
      .rsp_lead_span_b      (rsp_lead_span_b),
      .rsp_conversion_ready (rsp_conversion_ready),
      .rsp_base_ready       (rsp_base_ready),
      .rsp_span_b_ready     (rsp_span_b_ready),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[ichimoku_window_midpoints] ERROR");
         $finish;
      end
   end

   // Receiver: alternate between steady, choppy and mostly stalled stretches
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= $urandom_range(0, 2);
         rx_left <= $urandom_range(5, 150);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // Highest high plus lowest low over the newest min(length, held) bars
   function automatic logic [PRICE_BITS:0] window_span(input logic [LEN_BITS-1:0] len_reg,
                                                     output logic full);
      int unsigned len;
      int unsigned n;
      int unsigned idx;
      int unsigned k;
      price_type   hi;
      price_type   lo;
      len = 32'(len_reg);
      if (len == 0)
         len = 1;
      else if (len > WINDOW_MAX)
         len = WINDOW_MAX;
      n    = (len < bars_held) ? len : bars_held;
      full = (bars_held >= len);
      hi   = '0;
      lo   = '1;
      for (k = 0; k < n; k++) begin
         idx = (next_slot + 2 * WINDOW_MAX - 1 - k) % WINDOW_MAX;
         if (hist_high[idx] > hi) hi = hist_high[idx];
         if (hist_low[idx] < lo) lo = hist_low[idx];
      end
      return {1'b0, hi} + {1'b0, lo};
   endfunction

   function automatic void predict_midpoints(input price_type bar_high,
                                             input price_type bar_low);
      midpoint_set_type m;
      hist_high[next_slot] = bar_high;
      hist_low[next_slot]  = bar_low;
      next_slot = (next_slot + 1) % WINDOW_MAX;
      if (bars_held < WINDOW_MAX) bars_held++;
      m.conv   = window_span(conv_len, m.conv_full);
      m.base   = window_span(base_len, m.base_full);
      m.span_b = window_span(spanb_len, m.span_b_full);
      m.span_a = {1'b0, m.conv} + {1'b0, m.base};
      pending_midpoints.push_back(m);
   endfunction

   function automatic void check_field(input string name, input logic [CHK_W-1:0] want,
                                       input logic [CHK_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failed = 1'b1;
      end
   endfunction

   always @(posedge clock) begin : check_results
      midpoint_set_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_midpoints.size() == 0) begin
            $error("result transaction with no expected midpoints");
            failed = 1'b1;
         end else begin
            want = pending_midpoints.pop_front();
            check_field("conversion_line", CHK_W'(want.conv), CHK_W'(rsp_conversion_line));
            check_field("base_line", CHK_W'(want.base), CHK_W'(rsp_base_line));
            check_field("lead_span_a", want.span_a, rsp_lead_span_a);
            check_field("lead_span_b", CHK_W'(want.span_b), CHK_W'(rsp_lead_span_b));
            check_field("conversion_ready", CHK_W'(want.conv_full),
                        CHK_W'(rsp_conversion_ready));
            check_field("base_ready", CHK_W'(want.base_full), CHK_W'(rsp_base_ready));
            check_field("span_b_ready", CHK_W'(want.span_b_full), CHK_W'(rsp_span_b_ready));
         end
      end
   end

   // Sender pacing: bursts of random length separated by random gaps
   task automatic pace();
      int unsigned gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 80);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_bar(input price_type bar_high, input price_type bar_low);
      req_valid    <= 1'b1;
      req_bar_high <= bar_high;
      req_bar_low  <= bar_low;
      do @(posedge clock); while (!req_ready);
      predict_midpoints(bar_high, bar_low);
      pace();
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input logic [LEN_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CONV_LEN:  conv_len  = data;
         CSR_BASE_LEN:  base_len  = data;
         CSR_SPANB_LEN: spanb_len = data;
         default: ;
      endcase
   endtask

   // Call only while idle; the unused index write must leave every length alone
   task automatic set_lengths(input logic [LEN_BITS-1:0] conv, input logic [LEN_BITS-1:0] base,
                              input logic [LEN_BITS-1:0] spanb, input bit poke_unused);
      csr_write(CSR_CONV_LEN, conv);
      if (poke_unused) csr_write(CSR_UNUSED, LEN_BITS'($urandom));
      csr_write(CSR_BASE_LEN, base);
      csr_write(CSR_SPANB_LEN, spanb);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_midpoints.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic price_type random_price();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return price_type'($urandom_range(1000, 1100));
         3: return '1 - price_type'($urandom_range(0, 100));
         default: return price_type'($urandom);
      endcase
   endfunction

   function automatic logic [LEN_BITS-1:0] random_length();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return LEN_BITS'(1);
         2: return LEN_BITS'(WINDOW_MAX);
         3: return LEN_BITS'(WINDOW_MAX + 1);
         4: return '1;
         5: return LEN_BITS'($urandom_range(0, 127));
         default: return LEN_BITS'($urandom_range(1, 16));
      endcase
   endfunction

   // Default lengths while the base and span B windows are still filling
   task automatic test_fill_with_reset_lengths();
      send_bar(32'hFFFF_FFFF, 32'h0000_0000);
      send_bar(32'h0000_0000, 32'hFFFF_FFFF);
      send_bar(32'h0000_0000, 32'h0000_0000);
      send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_bar(32'h8000_0000, 32'h7FFF_FFFF);
      send_bar(32'h0000_0001, 32'h0000_0001);
      send_bar(32'hAAAA_AAAA, 32'h5555_5555);
      send_bar(32'h5555_5555, 32'hAAAA_AAAA);
      send_bar(32'h0000_1234, 32'h0000_1200);
      send_bar(32'h0000_1300, 32'h0000_1250);
      drain();
   endtask

   // Zero length, full capacity and lengths past capacity
   task automatic test_length_extremes();
      int unsigned i;
      set_lengths('0, LEN_BITS'(WINDOW_MAX), '1, 1'b1);
      for (i = 0; i < 6; i++) send_bar(price_type'($urandom), price_type'($urandom));
      drain();
      set_lengths(LEN_BITS'(1), LEN_BITS'(WINDOW_MAX + 1), LEN_BITS'(WINDOW_MAX), 1'b0);
      for (i = 0; i < 6; i++) send_bar(random_price(), random_price());
      drain();
   endtask

   task automatic test_random_phases();
      int unsigned sent;
      int unsigned count;
      sent = 0;
      while (sent < RANDOM_BARS) begin
         set_lengths(random_length(), random_length(), random_length(),
                     $urandom_range(0, 3) == 0);
         count = $urandom_range(20, 120);
         repeat (count) send_bar(random_price(), random_price());
         sent += count;
         drain();
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_bar_high = '0;
      req_bar_low  = '0;
      rsp_ready    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = CSR_CONV_LEN;
      csr_data     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_fill_with_reset_lengths();
      test_length_extremes();
      test_random_phases();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (!failed && pending_midpoints.size() == 0)
         $display("[ichimoku_window_midpoints] OK");
      else
         $display("[ichimoku_window_midpoints] ERROR");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ichi_pkg.sv
rtl/ichi_hist.sv
rtl/ichi_extreme.sv
rtl/ichimoku_window_midpoints.sv
tb/sv/tb.sv
